// ===== rtl/core/lbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Line buffer convolution package
// Shared constants, types and register indexes of the streaming 2-D
// convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

   localparam int KERNEL_DIM     = 3;
   localparam int LINE_CAP       = 1024;

   localparam int PIX_W          = 8;
   localparam int COEF_W         = 16;
   localparam int COEF_WORDS     = 4;
   localparam int COEFS_PER_WORD = 4;
   localparam int CSR_DATA_W     = 64;
   localparam int CSR_INDEX_W    = 3;
   localparam int WIDTH_W        = 11;
   localparam int HEIGHT_W       = 16;
   localparam int SHIFT_W        = 5;
   localparam int OUT_W          = 28;

   localparam int WIN_DEPTH      = KERNEL_DIM * KERNEL_DIM;
   localparam int COL_W          = $clog2(LINE_CAP + 1);
   localparam int ADDR_W         = $clog2(LINE_CAP);
   localparam int LINE_W         = (KERNEL_DIM - 1) * PIX_W;
   localparam int PROD_W         = PIX_W + 1 + COEF_W;
   localparam int ROW_W          = PROD_W + $clog2(KERNEL_DIM);
   localparam int SUM_W          = 32;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd768;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COEF_0 = 3'd0,
      CSR_COEF_1 = 3'd1,
      CSR_COEF_2 = 3'd2,
      CSR_COEF_3 = 3'd3,
      CSR_WIDTH  = 3'd4,
      CSR_HEIGHT = 3'd5,
      CSR_SHIFT  = 3'd6
   } csr_index_type;

   typedef logic [WIN_DEPTH-1:0][PIX_W-1:0]       win_type;
   typedef logic [COEF_WORDS-1:0][CSR_DATA_W-1:0] coef_set_type;

   // Valid and frame marker traveling with a window through the pipeline.
   typedef struct packed {
      logic valid;
      logic last;
   } ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/core/lbc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lbc_front.sv =====
// ----------------------------------------------------------------------------
// Line buffer front end
// Tracks the raster position, keeps the previous rows in a line RAM and
// shifts each new pixel column into the convolution window.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [lbc_pkg::PIX_W-1:0]     req_pixel,
   input  wire logic [lbc_pkg::WIDTH_W-1:0]   cfg_width,
   input  wire logic [lbc_pkg::HEIGHT_W-1:0]  cfg_height,
   output lbc_pkg::ctrl_type                  win_ctrl,
   output lbc_pkg::win_type                   win_pixels,
   input  wire logic                          win_ready
);

   import lbc_pkg::*;

   logic [COL_W-1:0]    col_ff;
   logic [HEIGHT_W-1:0] row_ff;

   logic [COL_W-1:0]    w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic                col_wrap;
   logic [HEIGHT_W-1:0] row_step;
   logic [HEIGHT_W-1:0] row_in;
   logic [COL_W-1:0]    c_cur;
   logic [COL_W-1:0]    col_in;
   logic                emit_in;
   logic                last_in;
   logic                accept;

   logic                s1_valid_ff;
   logic [PIX_W-1:0]    s1_pix_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic                s1_emit_ff;
   logic                s1_last_ff;
   logic                s1_byp_ff;
   logic [LINE_W-1:0]   byp_data_ff;
   logic                s1_fire;

   logic [LINE_W-1:0]   ram_rd_data;
   logic [LINE_W-1:0]   line_old;
   logic [LINE_W-1:0]   line_new;
   logic [KERNEL_DIM-1:0][PIX_W-1:0] column;

   win_type             win_ff;
   win_type             win_in;
   logic                s2_valid_ff;
   logic                s2_last_ff;
   logic                s2_ready;

   // Effective frame size: zero means one, widths saturate at the line capacity.
   always_comb begin
      if (cfg_width == '0) begin
         w_eff = COL_W'(1);
      end else if (32'(cfg_width) > LINE_CAP) begin
         w_eff = COL_W'(LINE_CAP);
      end else begin
         w_eff = COL_W'(cfg_width);
      end
      h_eff = (cfg_height == '0) ? HEIGHT_W'(1) : cfg_height;
   end

   always_comb begin
      col_wrap = col_ff >= w_eff;
      row_step = col_wrap ? row_ff + HEIGHT_W'(1) : row_ff;
      row_in   = (row_step >= h_eff) ? '0 : row_step;
      c_cur    = col_wrap ? '0 : col_ff;
      col_in   = c_cur + COL_W'(1);
      emit_in  = (32'(w_eff) >= KERNEL_DIM) && (32'(h_eff) >= KERNEL_DIM) &&
                 (32'(row_in) >= KERNEL_DIM - 1) && (32'(c_cur) >= KERNEL_DIM - 1);
      last_in  = (row_in == h_eff - HEIGHT_W'(1)) && (c_cur == w_eff - COL_W'(1));
   end

   assign s2_ready  = !s2_valid_ff || win_ready;
   assign s1_fire   = s1_valid_ff && s2_ready;
   assign req_ready = !s1_valid_ff || s1_fire;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // A read that meets the write of the previous pixel at the same column
   // sees the old RAM word, so the new word is kept aside for it.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff   <= req_pixel;
         s1_addr_ff  <= c_cur[ADDR_W-1:0];
         s1_emit_ff  <= emit_in;
         s1_last_ff  <= last_in;
         s1_byp_ff   <= s1_fire && (s1_addr_ff == c_cur[ADDR_W-1:0]);
         byp_data_ff <= line_new;
      end
   end

   lbc_ram #(
      .WIDTH (LINE_W),
      .DEPTH (LINE_CAP)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_addr_ff),
      .wr_data (line_new),
      .rd_en   (accept),
      .rd_addr (c_cur[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Column from oldest row to the new pixel; each row moves up one line.
   always_comb begin
      line_old = s1_byp_ff ? byp_data_ff : ram_rd_data;
      for (int r = 0; r < KERNEL_DIM - 1; r++) begin
         column[r] = line_old[r*PIX_W +: PIX_W];
      end
      column[KERNEL_DIM-1] = s1_pix_ff;
      for (int r = 0; r < KERNEL_DIM - 1; r++) begin
         line_new[r*PIX_W +: PIX_W] = column[r+1];
      end
   end

   always_comb begin
      for (int r = 0; r < KERNEL_DIM; r++) begin
         for (int k = 0; k < KERNEL_DIM - 1; k++) begin
            win_in[r*KERNEL_DIM + k] = win_ff[r*KERNEL_DIM + k + 1];
         end
         win_in[r*KERNEL_DIM + KERNEL_DIM - 1] = column[r];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         win_ff     <= win_in;
         s2_last_ff <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         s2_valid_ff <= s1_emit_ff;
      end else if (win_ready) begin
         s2_valid_ff <= 1'b0;
      end
   end

   assign win_ctrl.valid = s2_valid_ff;
   assign win_ctrl.last  = s2_last_ff;
   assign win_pixels     = win_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lbc_mac.sv =====
// ----------------------------------------------------------------------------
// Convolution multiply-accumulate pipeline
// Multiplies the window by the kernel, adds rows, adds the rounding bias and
// shifts, with one register stage after each step.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_mac (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lbc_pkg::ctrl_type             win_ctrl,
   input  wire lbc_pkg::win_type              win_pixels,
   output logic                               win_ready,
   input  wire lbc_pkg::coef_set_type         coef_words,
   input  wire logic [lbc_pkg::SHIFT_W-1:0]   shift_amt,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [lbc_pkg::OUT_W-1:0]   rsp_conv_value,
   output logic                               rsp_frame_last
);

   import lbc_pkg::*;

   ctrl_type prod_ctrl_ff, row_ctrl_ff, sum_ctrl_ff, out_ctrl_ff;
   logic     prod_ready, row_ready, sum_ready, out_ready;

   logic signed [PROD_W-1:0] prod_ff [WIN_DEPTH];
   logic signed [PROD_W-1:0] prod_in [WIN_DEPTH];
   logic signed [ROW_W-1:0]  row_ff  [KERNEL_DIM];
   logic signed [ROW_W-1:0]  row_in  [KERNEL_DIM];
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  bias;
   logic signed [OUT_W-1:0]  out_ff;
   logic signed [SUM_W-1:0]  shifted;

   assign out_ready  = !out_ctrl_ff.valid || rsp_ready;
   assign sum_ready  = !sum_ctrl_ff.valid || out_ready;
   assign row_ready  = !row_ctrl_ff.valid || sum_ready;
   assign prod_ready = !prod_ctrl_ff.valid || row_ready;
   assign win_ready  = prod_ready;

   always_comb begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
         prod_in[k] = PROD_W'($signed({1'b0, win_pixels[k]})) *
                      PROD_W'($signed(coef_words[k / COEFS_PER_WORD]
                                      [(k % COEFS_PER_WORD)*COEF_W +: COEF_W]));
      end
   end

   always_comb begin
      for (int r = 0; r < KERNEL_DIM; r++) begin
         row_in[r] = '0;
         for (int k = 0; k < KERNEL_DIM; k++) begin
            row_in[r] = row_in[r] + ROW_W'(prod_ff[r*KERNEL_DIM + k]);
         end
      end
   end

   // Rounding bias of half an output step when a shift is applied.
   always_comb begin
      bias = (shift_amt == '0) ? '0 : (SUM_W'(1) <<< (shift_amt - SHIFT_W'(1)));
      sum_in = bias;
      for (int r = 0; r < KERNEL_DIM; r++) begin
         sum_in = sum_in + SUM_W'(row_ff[r]);
      end
      shifted = sum_ff >>> shift_amt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ctrl_ff <= '0;
         row_ctrl_ff  <= '0;
         sum_ctrl_ff  <= '0;
         out_ctrl_ff  <= '0;
      end else begin
         if (prod_ready) begin
            prod_ctrl_ff <= win_ctrl;
         end
         if (row_ready) begin
            row_ctrl_ff <= prod_ctrl_ff;
         end
         if (sum_ready) begin
            sum_ctrl_ff <= row_ctrl_ff;
         end
         if (out_ready) begin
            out_ctrl_ff <= sum_ctrl_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready) begin
         prod_ff <= prod_in;
      end
      if (row_ready) begin
         row_ff <= row_in;
      end
      if (sum_ready) begin
         sum_ff <= sum_in;
      end
      if (out_ready) begin
         out_ff <= shifted[OUT_W-1:0];
      end
   end

   assign rsp_valid      = out_ctrl_ff.valid;
   assign rsp_frame_last = out_ctrl_ff.last;
   assign rsp_conv_value = out_ff;

endmodule

`default_nettype wire

// ===== rtl/core/line_buffer_conv2d.sv =====
// Results pass the stage-one, window, product, row, sum and output registers in turn.
// One pixel per cycle unless the output stalls; the line RAM is read and written once per pixel.
// Pixels outside the valid region are absorbed without producing a result.
// Reset clears the raster position, the pipeline and the registers to their defaults.
// The line RAM and the window are not cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Streaming 3x3 line buffer convolution
// Raster-order pixel input, signed rounded and shifted convolution output.
// ----------------------------------------------------------------------------
`default_nettype none

module line_buffer_conv2d (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [lbc_pkg::PIX_W-1:0]       req_pixel,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic signed [lbc_pkg::OUT_W-1:0]     rsp_conv_value,
   output logic                                 rsp_frame_last,
   input  wire logic                            csr_we,
   input  wire logic [lbc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lbc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import lbc_pkg::*;

   coef_set_type        coef_ff;
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [SHIFT_W-1:0]  shift_ff;

   ctrl_type            win_ctrl;
   win_type             win_pixels;
   logic                win_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff   <= '0;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         shift_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_COEF_0: coef_ff[0] <= csr_wdata;
            CSR_COEF_1: coef_ff[1] <= csr_wdata;
            CSR_COEF_2: coef_ff[2] <= csr_wdata;
            CSR_COEF_3: coef_ff[3] <= csr_wdata;
            CSR_WIDTH:  width_ff   <= csr_wdata[WIDTH_W-1:0];
            CSR_HEIGHT: height_ff  <= csr_wdata[HEIGHT_W-1:0];
            CSR_SHIFT:  shift_ff   <= csr_wdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   lbc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_pixel  (req_pixel),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .win_ctrl   (win_ctrl),
      .win_pixels (win_pixels),
      .win_ready  (win_ready)
   );

   lbc_mac u_mac (
      .clock          (clock),
      .reset          (reset),
      .win_ctrl       (win_ctrl),
      .win_pixels     (win_pixels),
      .win_ready      (win_ready),
      .coef_words     (coef_ff),
      .shift_amt      (shift_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_conv_value (rsp_conv_value),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Streaming 3x3 convolution testbench
// Feeds raster pixels through valid/ready with random gaps and output stalls,
// predicts every convolution result from a local line buffer and window
// model, and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;

   import lbc_pkg::*;

   // Widest frame used; every line buffer column below it is filled first.
   localparam int PREFILL_W = 64;

   typedef struct packed {
      logic [OUT_W-1:0] value;
      logic             last;
   } conv_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [PIX_W-1:0]        req_pixel = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_conv_value;
   logic                    rsp_frame_last;
   logic                    csr_we = 1'b0;
   csr_index_type           csr_index = CSR_COEF_0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // Local copy of the block's registers and storage.
   logic [CSR_DATA_W-1:0] coef_words [COEF_WORDS];
   int unsigned           cfg_width = WIDTH_RESET;
   int unsigned           cfg_height = HEIGHT_RESET;
   int unsigned           cfg_shift = 0;
   logic [PIX_W-1:0]      line_store [KERNEL_DIM-1][LINE_CAP];
   logic [PIX_W-1:0]      window [KERNEL_DIM][KERNEL_DIM];
   int unsigned           column_pos = 0;
   int unsigned           row_pos = 0;

   logic [PIX_W-1:0] pixel_backlog [$];
   conv_result_type  pending_convolutions [$];
   conv_result_type  oldest;
   int unsigned      result_count = 0;
   int unsigned      error_count = 0;
   int unsigned      send_idle_pct = 0;
   int unsigned      stall_pct = 0;
   int unsigned      stall_budget = 0;
   bit               pixel_taken = 1'b0;

   line_buffer_conv2d DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_conv_value (rsp_conv_value),
      .rsp_frame_last (rsp_frame_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Advances the raster position by one pixel and queues the result it causes.
   function automatic void convolve_pixel(input logic [PIX_W-1:0] pix);
      int unsigned      w;
      int unsigned      h;
      logic [PIX_W-1:0] fresh [KERNEL_DIM];
      longint           acc;
      logic [COEF_W-1:0] coef;
      conv_result_type  res;
      w = (cfg_width == 0) ? 1 : cfg_width;
      h = (cfg_height == 0) ? 1 : cfg_height;
      if (w > LINE_CAP) w = LINE_CAP;
      // Wrapping is lazy: it happens before the pixel, against the current sizes.
      if (column_pos >= w) begin
         column_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      for (int r = 0; r < KERNEL_DIM - 1; r++) fresh[r] = line_store[r][column_pos];
      fresh[KERNEL_DIM-1] = pix;
      for (int r = 0; r < KERNEL_DIM; r++) begin
         for (int c = 0; c < KERNEL_DIM - 1; c++) window[r][c] = window[r][c+1];
         window[r][KERNEL_DIM-1] = fresh[r];
      end
      for (int r = 0; r < KERNEL_DIM - 1; r++) line_store[r][column_pos] = fresh[r+1];
      if (w >= KERNEL_DIM && h >= KERNEL_DIM &&
          row_pos >= KERNEL_DIM - 1 && column_pos >= KERNEL_DIM - 1) begin
         acc = 0;
         for (int k = 0; k < WIN_DEPTH; k++) begin
            coef = coef_words[k / COEFS_PER_WORD][COEF_W * (k % COEFS_PER_WORD) +: COEF_W];
            acc += longint'(window[k / KERNEL_DIM][k % KERNEL_DIM]) *
                   longint'($signed(coef));
         end
         if (cfg_shift > 0) acc += longint'(1) << (cfg_shift - 1);
         acc = acc >>> cfg_shift;
         res.value = acc[OUT_W-1:0];
         res.last = (row_pos == h - 1) && (column_pos == w - 1);
         pending_convolutions.push_back(res);
         result_count++;
      end
      column_pos++;
   endfunction

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_WIDTH: begin
            cfg_width = data[WIDTH_W-1:0];
         end
         CSR_HEIGHT: begin
            cfg_height = data[HEIGHT_W-1:0];
         end
         CSR_SHIFT: begin
            cfg_shift = data[SHIFT_W-1:0];
         end
         default: begin
            coef_words[int'(idx)] = data;
         end
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_pixels(input int unsigned count);
      repeat (count) pixel_backlog.push_back(PIX_W'($urandom_range(0, 255)));
   endtask

   // Pixels outside the valid region give no result, so some margin follows
   // the last result before the block counts as idle.
   task automatic wait_idle();
      while (pixel_backlog.size() != 0 || req_valid) @(posedge clock);
      while (pending_convolutions.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   always @(posedge clock) begin
      pixel_taken = !reset && req_valid && req_ready;
      if (pixel_taken) convolve_pixel(req_pixel);
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || pixel_taken) begin
         if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_pixel <= pixel_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= (stall_budget == 0) && ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (stall_budget != 0) stall_budget <= stall_budget - 1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_convolutions.size() == 0) begin
            $error("unexpected result transfer: conv_value %0d, frame_last %0b",
                   rsp_conv_value, rsp_frame_last);
            error_count++;
         end else begin
            oldest = pending_convolutions.pop_front();
            if (rsp_conv_value !== oldest.value) begin
               $error("conv_value mismatch: expected %0d, got %0d",
                      $signed(oldest.value), rsp_conv_value);
               error_count++;
            end
            if (rsp_frame_last !== oldest.last) begin
               $error("frame_last mismatch: expected %0b, got %0b",
                      oldest.last, rsp_frame_last);
               error_count++;
            end
         end
      end
   end

   initial begin
      int unsigned random_items;
      int unsigned results_at_start;
      int unsigned round;
      int unsigned w_eff;
      int unsigned h_eff;
      int unsigned count;
      int          lane;
      logic [CSR_DATA_W-1:0] word;

      for (int i = 0; i < COEF_WORDS; i++) coef_words[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A frame at the widest width used later comes first, so that every
      // line buffer column in reach holds a written pixel before any size change.
      for (int i = 0; i < COEF_WORDS; i++)
         write_register(csr_index_type'(i), {$urandom, $urandom});
      write_register(CSR_WIDTH, 64'(PREFILL_W));
      write_register(CSR_HEIGHT, 64'd3);
      write_register(CSR_SHIFT, 64'd9);
      queue_pixels(KERNEL_DIM * PREFILL_W);
      wait_idle();

      // Largest positive sum: brightest pixels against the largest coefficients.
      write_register(CSR_COEF_0, 64'h7FFF_7FFF_7FFF_7FFF);
      write_register(CSR_COEF_1, 64'h7FFF_7FFF_7FFF_7FFF);
      write_register(CSR_COEF_2, 64'h7FFF_7FFF_7FFF_7FFF);
      write_register(CSR_WIDTH, 64'd3);
      write_register(CSR_SHIFT, 64'd0);
      repeat (WIN_DEPTH) pixel_backlog.push_back(8'hFF);
      wait_idle();

      // Most negative sum.
      write_register(CSR_COEF_0, 64'h8000_8000_8000_8000);
      write_register(CSR_COEF_1, 64'h8000_8000_8000_8000);
      write_register(CSR_COEF_2, 64'h8000_8000_8000_8000);
      repeat (WIN_DEPTH) pixel_backlog.push_back(8'hFF);
      wait_idle();

      // Zero sizes count as one: a frame too small to give any result.
      write_register(CSR_WIDTH, 64'd0);
      write_register(CSR_HEIGHT, 64'd0);
      pixel_backlog.push_back(8'h00);
      queue_pixels(3);
      wait_idle();

      random_items = 0;
      results_at_start = result_count;
      round = 0;
      while (random_items < 800 || result_count - results_at_start < 48) begin
         case (round % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 63;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 63;
            end
            default: begin
               send_idle_pct = 38;
               stall_pct = 38;
            end
         endcase
         if (round == 0) begin
            // Output held off for a long stretch so the pipeline backs up
            // into the input while pixels keep coming.
            write_register(CSR_WIDTH, 64'd4);
            write_register(CSR_HEIGHT, 64'd4);
            write_register(CSR_SHIFT, 64'd4);
            stall_budget = 300;
            count = 96;
         end else begin
            // Sometimes only the shift changes, so the frame carries on mid-way.
            if ($urandom_range(0, 3) != 0) begin
               for (int i = 0; i < COEF_WORDS; i++) begin
                  case ($urandom_range(0, 4))
                     0: word = {$urandom, $urandom};
                     1: word = 64'h7FFF_7FFF_7FFF_7FFF;
                     2: word = 64'h8000_8000_8000_8000;
                     default: begin
                        for (int j = 0; j < COEFS_PER_WORD; j++) begin
                           lane = int'($urandom_range(0, 512)) - 256;
                           word[COEF_W * j +: COEF_W] = lane[COEF_W-1:0];
                        end
                     end
                  endcase
                  write_register(csr_index_type'(i), word);
               end
               case ($urandom_range(0, 19))
                  0: word = 64'd0;
                  1, 2, 3: word = 64'($urandom_range(11, PREFILL_W));
                  default: word = 64'($urandom_range(1, 10));
               endcase
               write_register(CSR_WIDTH, word);
               case ($urandom_range(0, 9))
                  0: word = 64'd0;
                  1: word = 64'hFFFF;
                  2: word = 64'($urandom_range(7, 300));
                  default: word = 64'($urandom_range(1, 6));
               endcase
               write_register(CSR_HEIGHT, word);
            end
            word = $urandom_range(0, 1) ? 64'($urandom_range(0, 31)) :
                                          64'($urandom_range(0, 12));
            write_register(CSR_SHIFT, word);
            w_eff = (cfg_width == 0) ? 1 : ((cfg_width > LINE_CAP) ? LINE_CAP : cfg_width);
            h_eff = (cfg_height == 0) ? 1 : ((cfg_height > 6) ? 6 : cfg_height);
            count = w_eff * h_eff * $urandom_range(1, 2) + $urandom_range(0, 2);
            if (count > 300) count = 300;
         end
         queue_pixels(count);
         random_items += count;
         wait_idle();
         round++;
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== line_buffer_conv2d.f =====
rtl/core/lbc_pkg.sv
rtl/core/lbc_ram.sv
rtl/core/lbc_front.sv
rtl/core/lbc_mac.sv
rtl/core/line_buffer_conv2d.sv
sim/testbench.sv
